// ===== design/wsbr_pkg.sv =====
// Shared types and constants for the word stream bit reader.
// Item codes, result status codes and fixed field widths; no dependencies.
`default_nettype none

package wsbr_pkg;

  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned AVAIL_W    = 5;   // holds 0 to WORD_BITS
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CTR_W      = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ      = 3'd0,
    MODE_PUSH      = 3'd1,
    MODE_RESTART   = 3'd2,
    MODE_BITS_READ = 3'd3,
    MODE_EOF       = 3'd4,
    MODE_BITS_LEFT = 3'd5,
    MODE_FLUSH     = 3'd6
  } mode_e;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STARVED = 2'd2;

endpackage

`default_nettype wire

// ===== design/wsbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the word buffer of the bit reader; no package dependency.
`default_nettype none

module wsbr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/word_stream_bit_reader_unit.sv =====
// Channel  | signals                                  | direction
// ---------+------------------------------------------+----------
// in       | in_valid_i, in_ready_o, mode_i,          | to block
//          | bit_count_i, stream_word_i               |
// out      | out_valid_o, out_ready_i, value_o,       | from block
//          | status_o                                 |
//
// Non-read items give their result in the cycle after the transfer.
// A read of n bits runs as a series of steps: each step either
// refills the current word from the buffer RAM or takes up to 16 bits
// through the one shared extract shifter. The RAM read port is registered,
// so a refill and the following extract never share a cycle.
// Reset clears all state; the buffer RAM is left as is and is only read
// at entries already written. A stalled output holds the finished read.
//
// Top level of the word stream bit reader; uses wsbr_pkg and wsbr_ram.
`default_nettype none

module word_stream_bit_reader_unit #(
  parameter int unsigned BUFFER_WORDS = 8,
  parameter int unsigned MAX_BITS     = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [wsbr_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [wsbr_pkg::COUNT_W-1:0]     bit_count_i,
  input  wire logic [wsbr_pkg::WORD_BITS-1:0]   stream_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [wsbr_pkg::VALUE_W-1:0]     value_o,
  output logic      [wsbr_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned PTR_W  = $clog2(BUFFER_WORDS);
  localparam int unsigned FILL_W = $clog2(BUFFER_WORDS + 1);
  localparam int unsigned WB     = wsbr_pkg::WORD_BITS;
  localparam int unsigned AW     = wsbr_pkg::AVAIL_W;
  localparam int unsigned CW     = wsbr_pkg::COUNT_W;
  localparam int unsigned VW     = wsbr_pkg::VALUE_W;
  localparam int unsigned SW     = wsbr_pkg::STATUS_W;
  localparam int unsigned KW     = wsbr_pkg::CTR_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_e;

  st_e            state_q, state_d;
  logic [WB-1:0]  cur_q, cur_d;
  logic [AW-1:0]  avail_q, avail_d;       // bits left below the pointer
  logic [KW-1:0]  consumed_q, consumed_d;
  logic [KW-1:0]  supplied_q, supplied_d;
  logic           end_q, end_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic [VW-1:0]  acc_q, acc_d;
  logic           starved_q, starved_d;
  logic           out_valid_q, out_valid_d;
  logic [VW-1:0]  out_value_q, out_value_d;
  logic [SW-1:0]  out_status_q, out_status_d;

  logic           ram_we;
  logic [WB-1:0]  ram_rdata;
  logic           in_xfer;
  logic           out_free;
  logic [CW-1:0]  n_sat;
  logic [AW-1:0]  take;
  logic [WB-1:0]  chunk;
  logic [WB-1:0]  mask;

  wsbr_ram #(
    .WIDTH (WB),
    .DEPTH (BUFFER_WORDS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (stream_word_i),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  assign n_sat = (bit_count_i > CW'(MAX_BITS)) ? CW'(MAX_BITS) : bit_count_i;

  // Shared extract unit: next chunk of up to one word, MSB first
  assign take  = (rem_q < CW'(avail_q)) ? rem_q[AW-1:0] : avail_q;
  assign mask  = WB'(((WB+1)'(1) << take) - (WB+1)'(1));
  assign chunk = (cur_q >> (avail_q - take)) & mask;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    avail_d      = avail_q;
    consumed_d   = consumed_q;
    supplied_d   = supplied_q;
    end_d        = end_q;
    fill_d       = fill_q;
    head_d       = head_q;
    tail_d       = tail_q;
    n_d          = n_q;
    rem_d        = rem_q;
    acc_d        = acc_q;
    starved_d    = starved_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          out_value_d  = '0;
          out_status_d = wsbr_pkg::STATUS_OK;
          unique case (wsbr_pkg::mode_e'(mode_i))
            wsbr_pkg::MODE_READ: begin
              n_d       = n_sat;
              rem_d     = n_sat;
              acc_d     = '0;
              starved_d = 1'b0;
              state_d   = ST_RUN;
            end
            wsbr_pkg::MODE_PUSH: begin
              out_valid_d = 1'b1;
              if (fill_q < FILL_W'(BUFFER_WORDS)) begin
                ram_we = 1'b1;
                fill_d = fill_q + FILL_W'(1);
                tail_d = (tail_q == PTR_W'(BUFFER_WORDS - 1)) ? '0 : tail_q + PTR_W'(1);
              end else begin
                out_status_d = wsbr_pkg::STATUS_FULL;
              end
            end
            wsbr_pkg::MODE_RESTART: begin
              out_valid_d = 1'b1;
              consumed_d  = '0;
              supplied_d  = '0;
              out_value_d = VW'(1);
            end
            wsbr_pkg::MODE_BITS_READ: begin
              out_valid_d = 1'b1;
              out_value_d = VW'(consumed_q);
            end
            wsbr_pkg::MODE_EOF: begin
              out_valid_d = 1'b1;
              out_value_d = VW'(end_q);
            end
            wsbr_pkg::MODE_BITS_LEFT: begin
              out_valid_d = 1'b1;
              out_value_d = VW'(avail_q);
            end
            wsbr_pkg::MODE_FLUSH: begin
              out_valid_d = 1'b1;
              cur_d       = '0;
              avail_d     = '0;
              end_d       = 1'b0;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_RUN: begin
        if (rem_q == '0) begin
          // hold the finished read until the output slot is free
          if (out_free) begin
            consumed_d   = consumed_q + KW'(n_q);
            if (consumed_d == supplied_q) begin
              end_d = 1'b1;
            end
            out_valid_d  = 1'b1;
            out_value_d  = acc_q;
            out_status_d = starved_q ? wsbr_pkg::STATUS_STARVED : wsbr_pkg::STATUS_OK;
            state_d      = ST_IDLE;
          end
        end else if (avail_q == '0) begin
          // refill: an empty buffer reuses the old word
          avail_d = AW'(WB);
          if (fill_q != '0) begin
            cur_d      = ram_rdata;
            fill_d     = fill_q - FILL_W'(1);
            head_d     = (head_q == PTR_W'(BUFFER_WORDS - 1)) ? '0 : head_q + PTR_W'(1);
            supplied_d = supplied_q + KW'(WB);
            end_d      = 1'b0;
          end else begin
            starved_d = 1'b1;
          end
        end else begin
          acc_d   = (acc_q << take) | VW'(chunk);
          avail_d = avail_q - take;
          rem_d   = rem_q - CW'(take);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      avail_q      <= '0;
      consumed_q   <= '0;
      supplied_q   <= '0;
      end_q        <= 1'b0;
      fill_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      n_q          <= '0;
      rem_q        <= '0;
      acc_q        <= '0;
      starved_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= wsbr_pkg::STATUS_OK;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      avail_q      <= avail_d;
      consumed_q   <= consumed_d;
      supplied_q   <= supplied_d;
      end_q        <= end_d;
      fill_q       <= fill_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      n_q          <= n_d;
      rem_q        <= rem_d;
      acc_q        <= acc_d;
      starved_q    <= starved_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(BUFFER_WORDS))
    else $error("word buffer fill beyond depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (tail_q == head_q))
    else $error("empty buffer with head and tail apart");

  a_idle_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (avail_q < AW'(WB)))
    else $error("full word left unread at end of item");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rem_q <= n_q) && (n_q <= CW'(MAX_BITS)))
    else $error("remaining bit count out of range");

  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && rem_q == '0 && out_free) |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished read did not post a result");
`endif

endmodule

`default_nettype wire

// ===== sim/word_stream_bit_reader_checker.sv =====
// Transfer monitor, predictor and scoreboard for the word stream bit reader.
// Depends on wsbr_pkg; the testbench top places it beside the block.
`timescale 1ns / 1ps

module word_stream_bit_reader_checker
  import wsbr_pkg::*;
#(
  parameter int unsigned BUFFER_WORDS = 8,
  parameter int unsigned MAX_BITS     = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [MODE_W-1:0]      mode_i,
  input  wire logic [COUNT_W-1:0]     bit_count_i,
  input  wire logic [WORD_BITS-1:0]   stream_word_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  input  wire logic [VALUE_W-1:0]     value_i,
  input  wire logic [STATUS_W-1:0]    status_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  // Predicted reader state
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] bit_ptr;
  logic [CTR_W-1:0]     consumed_bits;
  logic [CTR_W-1:0]     supplied_bits;
  logic                 end_flag;
  logic [WORD_BITS-1:0] word_store [BUFFER_WORDS];
  int unsigned          store_fill;
  int unsigned          store_head;

  // Results still owed by the block, oldest first
  logic [VALUE_W-1:0]   due_value_q [$];
  logic [STATUS_W-1:0]  due_status_q [$];
  logic [VALUE_W-1:0]   want_value;
  logic [STATUS_W-1:0]  want_status;
  int unsigned          fails;

  task automatic advance_reader(input logic [MODE_W-1:0] mode,
                                input logic [COUNT_W-1:0] count,
                                input logic [WORD_BITS-1:0] word);
    logic [VALUE_W-1:0]  val;
    logic [STATUS_W-1:0] st;
    logic                starved;
    int unsigned         n;
    val     = '0;
    st      = STATUS_OK;
    starved = 1'b0;
    case (mode)
      MODE_READ: begin
        n = (32'(count) > MAX_BITS) ? MAX_BITS : 32'(count);
        for (int unsigned i = 0; i < n; i++) begin
          bit_ptr = bit_ptr >> 1;
          if (bit_ptr == '0) begin
            // pointer ran out: take the next word, or restart the old one
            bit_ptr = 16'h8000;
            if (store_fill != 0) begin
              cur_word      = word_store[store_head];
              store_head    = (store_head + 1) % BUFFER_WORDS;
              store_fill    = store_fill - 1;
              supplied_bits = supplied_bits + CTR_W'(WORD_BITS);
              end_flag      = 1'b0;
            end else begin
              starved = 1'b1;
            end
          end
          val = {val[VALUE_W-2:0], |(cur_word & bit_ptr)};
        end
        consumed_bits = consumed_bits + CTR_W'(n);
        if (consumed_bits == supplied_bits) end_flag = 1'b1;
        if (starved) st = STATUS_STARVED;
      end
      MODE_PUSH: begin
        if (store_fill < BUFFER_WORDS) begin
          word_store[(store_head + store_fill) % BUFFER_WORDS] = word;
          store_fill = store_fill + 1;
        end else begin
          st = STATUS_FULL;
        end
      end
      MODE_RESTART: begin
        consumed_bits = '0;
        supplied_bits = '0;
        val           = 64'd1;
      end
      MODE_BITS_READ: val = VALUE_W'(consumed_bits);
      MODE_EOF:       val = VALUE_W'(end_flag);
      MODE_BITS_LEFT: begin
        for (int unsigned b = 0; b < WORD_BITS; b++) if (bit_ptr[b]) val = VALUE_W'(b);
      end
      MODE_FLUSH: begin
        bit_ptr  = '0;
        cur_word = '0;
        end_flag = 1'b0;
      end
      default: ;
    endcase
    due_value_q.push_back(val);
    due_status_q.push_back(st);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_word      = '0;
      bit_ptr       = '0;
      consumed_bits = '0;
      supplied_bits = '0;
      end_flag      = 1'b0;
      store_fill    = 0;
      store_head    = 0;
      fails         = 0;
      due_value_q.delete();
      due_status_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // compare first: a result can never belong to an item taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (due_value_q.size() == 0) begin
          $display("%0t: unexpected result, value %h status %0d", $time, value_i,
                   status_i);
          fails++;
        end else begin
          want_value  = due_value_q.pop_front();
          want_status = due_status_q.pop_front();
          if (value_i !== want_value) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want_value,
                     value_i);
            fails++;
          end
          if (status_i !== want_status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want_status, status_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) advance_reader(mode_i, bit_count_i, stream_word_i);
      fail_count_o <= fails;
      pending_o    <= unsigned'(due_value_q.size());
    end
  end

endmodule

// ===== sim/word_stream_bit_reader_unit_tb.sv =====
// Testbench top for the word stream bit reader: clock, reset, stimulus, verdict.
// Depends on wsbr_pkg, word_stream_bit_reader_unit and word_stream_bit_reader_checker.
`timescale 1ns / 1ps

module word_stream_bit_reader_unit_tb;
  import wsbr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 120;
  localparam int IDLE_PCT  [5]  = '{0, 51, 0, 9, 0};
  localparam int STALL_PCT [5]  = '{0, 0, 51, 9, 0};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [MODE_W-1:0]     mode          = '0;
  logic [COUNT_W-1:0]    bit_count     = '0;
  logic [WORD_BITS-1:0]  stream_word   = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [VALUE_W-1:0]    value;
  logic [STATUS_W-1:0]   status;
  int unsigned           fail_count;
  int unsigned           pending;

  int                    idle_pct      = 0;
  int                    stall_pct     = 0;
  logic                  hold_req      = 1'b0;
  logic                  hold_done     = 1'b0;
  int                    hold_left     = 0;
  int                    quiet_cycles  = 0;

  always #6 clk_i = ~clk_i;

  word_stream_bit_reader_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .bit_count_i   (bit_count),
    .stream_word_i (stream_word),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .value_o       (value),
    .status_o      (status)
  );

  word_stream_bit_reader_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .mode_i        (mode),
    .bit_count_i   (bit_count),
    .stream_word_i (stream_word),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .value_i       (value),
    .status_i      (status),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= (int'($urandom_range(0, 99)) >= stall_pct);
    end
  end

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and return at the edge where it transfers
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [COUNT_W-1:0] c,
                           input logic [WORD_BITS-1:0] w);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    bit_count   <= c;
    stream_word <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Mostly pushes and reads so the buffer keeps cycling; queries and the rest mixed in
  task automatic send_random_item();
    int unsigned            pick;
    int unsigned            span;
    logic [MODE_W-1:0]      m;
    logic [COUNT_W-1:0]     c;
    logic [WORD_BITS-1:0]   w;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 99);
    w    = WORD_BITS'($urandom());
    c    = COUNT_W'($urandom());
    if (pick < 40) begin
      m = MODE_PUSH;
    end else if (pick < 75) begin
      m = MODE_READ;
      if (span < 8)       c = '0;
      else if (span < 60) c = COUNT_W'($urandom_range(1, 16));
      else if (span < 88) c = COUNT_W'($urandom_range(17, 64));
      else                c = COUNT_W'($urandom_range(65, 127));
    end else if (pick < 80) begin
      m = MODE_BITS_READ;
    end else if (pick < 85) begin
      m = MODE_EOF;
    end else if (pick < 90) begin
      m = MODE_BITS_LEFT;
    end else if (pick < 94) begin
      m = MODE_FLUSH;
    end else if (pick < 97) begin
      m = MODE_RESTART;
    end else begin
      m = MODE_UNUSED;
    end
    send_item(m, c, w);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-buffer refill, full buffer, zero-bit eof, saturation, flush
    send_item(MODE_BITS_READ, '0, '0);
    send_item(MODE_EOF, '0, '0);
    send_item(MODE_READ, 7'd5, 16'hFFFF);
    send_item(MODE_PUSH, 7'd127, 16'hFFFF);
    send_item(MODE_PUSH, '0, 16'h0000);
    send_item(MODE_PUSH, '0, 16'h8001);
    send_item(MODE_PUSH, '0, 16'h7FFE);
    send_item(MODE_PUSH, '0, 16'hA5A5);
    send_item(MODE_PUSH, '0, 16'h5A5A);
    send_item(MODE_PUSH, '0, 16'h1234);
    send_item(MODE_PUSH, '0, 16'hFEDC);
    send_item(MODE_PUSH, '0, 16'h0F0F);
    send_item(MODE_RESTART, '0, '0);
    send_item(MODE_READ, 7'd0, '0);
    send_item(MODE_EOF, '0, '0);
    send_item(MODE_READ, 7'd64, '0);
    send_item(MODE_READ, 7'd127, '0);
    send_item(MODE_BITS_LEFT, '0, '0);
    send_item(MODE_BITS_READ, '0, '0);
    send_item(MODE_READ, 7'd16, '0);
    send_item(MODE_FLUSH, '0, '0);
    send_item(MODE_BITS_LEFT, '0, '0);
    send_item(MODE_UNUSED, 7'd127, 16'hFFFF);
    send_item(MODE_RESTART, '0, '0);
    send_item(MODE_PUSH, '0, 16'hC3C3);
    send_item(MODE_READ, 7'd16, '0);
    send_item(MODE_EOF, '0, '0);

    for (int p = 0; p < 5; p++) begin
      idle_pct = IDLE_PCT[p];
      stall_pct <= STALL_PCT[p];
      // last phase: receiver holds off while items keep coming
      if (p == 4) hold_req <= 1'b1;
      repeat (PHASE_ITEMS) send_random_item();
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wsbr_pkg.sv
design/wsbr_ram.sv
design/word_stream_bit_reader_unit.sv
sim/word_stream_bit_reader_checker.sv
sim/word_stream_bit_reader_unit_tb.sv
